// ===== src/int_to_padded_decimal_ascii_core_macros.svh =====
// Assertion macros for the decimal ASCII field formatter.
// Included by int_to_padded_decimal_ascii_core; no other dependencies.
`ifndef INT_TO_PADDED_DECIMAL_ASCII_CORE_MACROS_SVH
`define INT_TO_PADDED_DECIMAL_ASCII_CORE_MACROS_SVH
`ifndef SYNTH
`define ITOA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ITOA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ITOA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ITOA_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== src/itoa_pkg.sv =====
// Types, constants and helper functions for the decimal ASCII field formatter.
// No dependencies.
`timescale 1ns / 1ps
package itoa_pkg;
    localparam int VALUE_W    = 31;
    localparam int CHAR_W     = 8;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int ND_W       = 4;
    localparam int BITCNT_W   = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam int FW_W       = 6;

    localparam logic [CFG_IDX_W-1:0] REG_FIELD_WIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_CHAR    = 1'b1;

    localparam logic [FW_W-1:0]     FIELD_WIDTH_RESET = 6'd0;
    localparam logic [CHAR_W-1:0]   PAD_CHAR_RESET    = 8'd32;
    localparam logic [CHAR_W-1:0]   ASCII_ZERO        = 8'h30;
    localparam logic [BITCNT_W-1:0] LAST_BIT          = 5'(VALUE_W - 1);
    localparam logic [ND_W-1:0]     ND_FULL           = 4'(NUM_DIGITS);
    localparam logic [ND_W-1:0]     ND_ONE            = 4'd1;

    typedef logic [BCD_W-1:0] bcd_t;

    function automatic logic [3:0] dabble_digit(input logic [3:0] d);
        logic [3:0] r;
        r = (d >= 4'd5) ? d + 4'd3 : d;
        return r;
    endfunction

    function automatic bcd_t dabble_all(input bcd_t b);
        bcd_t r;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            r[4*i +: 4] = dabble_digit(b[4*i +: 4]);
        end
        return r;
    endfunction
endpackage

// ===== src/int_to_padded_decimal_ascii_core.sv =====
// Decimal ASCII field formatter: one value in, a right-aligned decimal field out.
// Depends on itoa_pkg and int_to_padded_decimal_ascii_core_macros.svh.
//
//   Channel  Ports                       Direction  Word
//   s_       s_valid s_ready s_value     in         one 31-bit value
//   m_       m_valid m_ready m_char_out  out        one character, m_is_last on the final one
//   cfg_     cfg_we cfg_index cfg_data   in         register write, no handshake
//
// A value is converted by shift-and-add-three, one bit per cycle, then
// leading zero digits are shifted out one digit per cycle, and the field is sent one
// character per cycle while the output is not stalled. A new value is accepted only
// once the last character of the field has been loaded for output.
// Reset clears the control state and sets field_width to 0 and pad_char to a space.
// A stalled output holds the fill and digit output; a new value is taken while the last word waits.
`timescale 1ns / 1ps
`include "int_to_padded_decimal_ascii_core_macros.svh"
module int_to_padded_decimal_ascii_core
    import itoa_pkg::*;
#(
    parameter int MAX_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [VALUE_W-1:0]    s_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CHAR_W-1:0]     m_char_out,
    output logic                  m_is_last,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);
    localparam int CNT_W = $clog2(MAX_WIDTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_TRIM,
        ST_PAD,
        ST_EMIT
    } state_t;

    state_t               state_reg;
    logic [FW_W-1:0]      field_width_reg;
    logic [CHAR_W-1:0]    pad_char_reg;
    logic [VALUE_W-1:0]   bin_reg;
    bcd_t                 bcd_reg;
    logic [BITCNT_W-1:0]  bit_cnt_reg;
    logic [ND_W-1:0]      nd_reg;
    logic [CNT_W-1:0]     pad_cnt_reg;
    logic                 m_valid_reg;
    logic [CHAR_W-1:0]    m_char_reg;
    logic                 m_last_reg;

    bcd_t                 bcd_fixed;
    logic [3:0]           top_digit;
    logic [CNT_W-1:0]     width_eff;
    logic [CNT_W-1:0]     nd_ext;
    logic [CNT_W-1:0]     pad_next;
    logic                 out_free;
    logic                 out_load;

    assign bcd_fixed = dabble_all(bcd_reg);
    assign top_digit = bcd_reg[BCD_W-1 -: 4];
    assign width_eff = (32'(field_width_reg) > 32'(MAX_WIDTH)) ? CNT_W'(MAX_WIDTH)
                                                                : CNT_W'(field_width_reg);
    assign nd_ext    = CNT_W'(nd_reg);
    assign pad_next  = (width_eff > nd_ext) ? width_eff - nd_ext : '0;
    assign out_free  = !m_valid_reg || m_ready;
    assign out_load  = out_free && ((state_reg == ST_PAD && pad_cnt_reg != '0)
                                    || state_reg == ST_EMIT);

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_char_out = m_char_reg;
    assign m_is_last  = m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            field_width_reg <= FIELD_WIDTH_RESET;
            pad_char_reg    <= PAD_CHAR_RESET;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_FIELD_WIDTH: field_width_reg <= cfg_data[FW_W-1:0];
                    REG_PAD_CHAR:    pad_char_reg    <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        bin_reg     <= s_value;
                        bcd_reg     <= '0;
                        bit_cnt_reg <= '0;
                        nd_reg      <= ND_FULL;
                        state_reg   <= ST_CONV;
                    end
                end
                ST_CONV: begin
                    bcd_reg     <= {bcd_fixed[BCD_W-2:0], bin_reg[VALUE_W-1]};
                    bin_reg     <= {bin_reg[VALUE_W-2:0], 1'b0};
                    bit_cnt_reg <= bit_cnt_reg + 1'b1;
                    if (bit_cnt_reg == LAST_BIT) begin
                        state_reg <= ST_TRIM;
                    end
                end
                ST_TRIM: begin
                    if (top_digit == 4'd0 && nd_reg != ND_ONE) begin
                        bcd_reg <= {bcd_reg[BCD_W-5:0], 4'd0};
                        nd_reg  <= nd_reg - 1'b1;
                    end else begin
                        pad_cnt_reg <= pad_next;
                        state_reg   <= ST_PAD;
                    end
                end
                ST_PAD: begin
                    if (pad_cnt_reg == '0) begin
                        state_reg <= ST_EMIT;
                    end else if (out_free) begin
                        m_char_reg  <= pad_char_reg;
                        m_last_reg  <= 1'b0;
                        pad_cnt_reg <= pad_cnt_reg - 1'b1;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_char_reg  <= ASCII_ZERO + {4'd0, top_digit};
                        m_last_reg  <= (nd_reg == ND_ONE);
                        bcd_reg     <= {bcd_reg[BCD_W-5:0], 4'd0};
                        nd_reg      <= nd_reg - 1'b1;
                        if (nd_reg == ND_ONE) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `ITOA_ASSERT_IMP(a_idle_word_is_last, aclk, aresetn, s_ready && m_valid, m_is_last)
    `ITOA_ASSERT_IMP(a_digit_is_decimal, aclk, aresetn,
                     state_reg == ST_TRIM || state_reg == ST_EMIT, top_digit <= 4'd9)
    `ITOA_ASSERT_IMP(a_digit_count_nonzero, aclk, aresetn,
                     state_reg == ST_TRIM || state_reg == ST_PAD || state_reg == ST_EMIT,
                     nd_reg != 4'd0)
    `ITOA_ASSERT_NXT(a_accept_starts_conv, aclk, aresetn, s_valid && s_ready,
                     state_reg == ST_CONV && !s_ready)
endmodule

// ===== dv/itoa_field_checker.sv =====
// Checker for the decimal ASCII field formatter: predicts each field and compares the words.
// Watches the input, result and register-write ports. Depends on itoa_pkg.
`timescale 1ns / 1ps
module itoa_field_checker
    import itoa_pkg::*;
#(
    parameter int MAX_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [VALUE_W-1:0]    s_value,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [CHAR_W-1:0]     m_char_out,
    input  logic                  m_is_last,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    chars_due,
    output int                    values_taken,
    output int                    chars_matched
);
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } field_char_t;

    field_char_t       due_chars[$];
    logic [FW_W-1:0]   width_reg;
    logic [CHAR_W-1:0] fill_reg;

    task automatic queue_field(input logic [VALUE_W-1:0] value);
        logic [3:0]  digit[NUM_DIGITS];
        logic [31:0] rest;
        int          nd;
        int          width;
        field_char_t c;
        rest = 32'(value);
        nd = 0;
        while (nd == 0 || rest != 0) begin
            digit[nd] = 4'(rest % 10);
            rest = rest / 10;
            nd++;
        end
        width = (int'(width_reg) > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
        for (int i = nd; i < width; i++) begin
            c.code = fill_reg;
            c.last = 1'b0;
            due_chars.push_back(c);
        end
        for (int i = nd - 1; i >= 0; i--) begin
            c.code = ASCII_ZERO + CHAR_W'(digit[i]);
            c.last = (i == 0);
            due_chars.push_back(c);
        end
    endtask

    always @(posedge aclk) begin
        field_char_t want;
        if (!aresetn) begin
            due_chars.delete();
            width_reg <= FIELD_WIDTH_RESET;
            fill_reg <= PAD_CHAR_RESET;
            mismatches <= 0;
            chars_due <= 0;
            values_taken <= 0;
            chars_matched <= 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_FIELD_WIDTH) begin
                    width_reg <= cfg_data[FW_W-1:0];
                end else if (cfg_index == REG_PAD_CHAR) begin
                    fill_reg <= cfg_data;
                end
            end
            // The word leaving is always older than any value taken at the same edge.
            if (m_valid && m_ready) begin
                if (due_chars.size() == 0) begin
                    $display("%0t: character %02h (last %0b) arrived with nothing expected",
                             $time, m_char_out, m_is_last);
                    mismatches <= mismatches + 1;
                end else begin
                    want = due_chars.pop_front();
                    if (want.code !== m_char_out || want.last !== m_is_last) begin
                        $display("%0t: expected char %02h last %0b, got char %02h last %0b",
                                 $time, want.code, want.last, m_char_out, m_is_last);
                        mismatches <= mismatches + 1;
                    end else begin
                        chars_matched <= chars_matched + 1;
                    end
                end
            end
            if (s_valid && s_ready) begin
                queue_field(s_value);
                values_taken <= values_taken + 1;
            end
            chars_due <= due_chars.size();
        end
    end
endmodule

// ===== dv/tb_top.sv =====
// Top of the testbench for the decimal ASCII field formatter: clock, reset, stimulus, verdict.
// Depends on itoa_pkg, int_to_padded_decimal_ascii_core and itoa_field_checker.
`timescale 1ns / 1ps
module tb_top;
    import itoa_pkg::*;

    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 17;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [VALUE_W-1:0]    s_value;
    logic                  m_valid;
    logic                  m_ready;
    logic [CHAR_W-1:0]     m_char_out;
    logic                  m_is_last;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int mismatches;
    int chars_due;
    int values_taken;
    int chars_matched;
    int formats_used;
    int quiet_cycles;
    bit calm;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    int_to_padded_decimal_ascii_core dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_value(s_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_char_out(m_char_out),
        .m_is_last(m_is_last),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    itoa_field_checker field_check (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_value(s_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_char_out(m_char_out),
        .m_is_last(m_is_last),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .mismatches(mismatches),
        .chars_due(chars_due),
        .values_taken(values_taken),
        .chars_matched(chars_matched)
    );

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
            $display("tb_top: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int hold;
        hold = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (!calm && hold == 0 && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(1, 17);
            end
            if (hold != 0 && !calm) begin
                hold--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_value(input logic [VALUE_W-1:0] value);
        int gap;
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (chars_due != 0) @(posedge aclk);
    endtask

    task automatic set_format(input logic [CFG_DATA_W-1:0] width_data,
                              input logic [CFG_DATA_W-1:0] fill);
        cfg_we <= 1'b1;
        cfg_index <= REG_FIELD_WIDTH;
        cfg_data <= width_data;
        @(posedge aclk);
        cfg_index <= REG_PAD_CHAR;
        cfg_data <= fill;
        @(posedge aclk);
        cfg_we <= 1'b0;
        formats_used++;
    endtask

    function automatic logic [VALUE_W-1:0] random_value();
        int     nd;
        longint lo;
        longint hi;
        if ($urandom_range(0, 4) == 0) begin
            return VALUE_W'($urandom);
        end
        nd = $urandom_range(1, NUM_DIGITS);
        lo = 1;
        repeat (nd - 1) lo = lo * 10;
        hi = lo * 10 - 1;
        if (nd == 1) lo = 0;
        if (hi > 64'd2147483647) hi = 64'd2147483647;
        return VALUE_W'($urandom_range(32'(hi), 32'(lo)));
    endfunction

    initial begin
        logic [CFG_DATA_W-1:0] width_data;
        calm = 1'b0;
        formats_used = 0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_value <= '0;
        cfg_we <= 1'b0;
        cfg_index <= REG_FIELD_WIDTH;
        cfg_data <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // No padding: single digits, decade edges and the largest value.
        set_format(8'd0, 8'd32);
        send_value(31'd0);
        send_value(31'd1);
        send_value(31'd9);
        send_value(31'd10);
        send_value(31'd99);
        send_value(31'd100);
        send_value(31'd2147483647);
        send_value(31'd1000000000);
        send_value(31'd999999999);
        drain();
        set_format(8'd10, 8'h2A);
        send_value(31'd0);
        send_value(31'd123);
        send_value(31'd2147483647);
        send_value(31'd1234567890);
        drain();
        set_format(8'd32, 8'h00);
        send_value(31'd0);
        send_value(31'd5);
        drain();
        // Upper bits of the width data are dropped and the width is then capped.
        set_format(8'hFF, 8'hFF);
        send_value(31'd7);
        send_value(31'd2147483647);
        drain();
        set_format(8'd33, 8'h30);
        send_value(31'd42);
        drain();
        set_format(8'd1, 8'h23);
        send_value(31'd0);
        send_value(31'd55);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            width_data = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, 255))
                                                     : CFG_DATA_W'($urandom_range(0, 12));
            set_format(width_data, CFG_DATA_W'($urandom_range(0, 255)));
            calm = (p == RANDOM_PHASES - 1);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                send_value(random_value());
            end
            drain();
        end

        repeat (20) @(posedge aclk);
        $display("Converted %0d values into %0d checked characters under %0d formats,",
                 values_taken, chars_matched, formats_used);
        $display("with random stalls on both channels and a final stretch without any.");
        if (mismatches == 0 && chars_due == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule
